>>> sv/thermocouple_scratchpad_decoder_defines.svh
// ----------------------------------------------------------------------------
// Thermocouple scratchpad decoder assertion macros
// Concurrent check macros used by the decoder's RTL file.
// ----------------------------------------------------------------------------
`ifndef THERMOCOUPLE_SCRATCHPAD_DECODER_DEFINES_SVH
`define THERMOCOUPLE_SCRATCHPAD_DECODER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tsd_pkg.sv
// ----------------------------------------------------------------------------
// Thermocouple scratchpad decoder package
// Frame geometry, result layout and the bytewise 1-Wire CRC-8 update.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int unsigned PAD_BYTES  = 9;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned KEEP_BYTES = 4;
  localparam int unsigned IN_W       = 8;
  localparam int unsigned OUT_W      = 32;
  localparam logic [7:0]  CRC_POLY   = 8'h8C;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAD_BYTES - 1);

  typedef struct packed {
    logic [2:0]         fault_bits;
    logic signed [13:0] couple_temp;
    logic signed [11:0] cold_temp;
    logic               crc_ok;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> sv/thermocouple_scratchpad_decoder.sv
// ----------------------------------------------------------------------------
// Thermocouple scratchpad decoder
// Checks the CRC-8 of a nine-byte scratchpad and decodes its temperatures.
// ----------------------------------------------------------------------------
// Channel  | Direction | tdata                         | tuser
// s_axis   | in        | [7:0] scratch_byte            | frame_start
// m_axis   | out       | crc_ok, junction, couple, ... | none
//
// One byte per cycle unless m_axis stalls; its result, if any, is registered.
// The CRC update of one byte in the processing stage sets the cycle time.
// Reset clears the frame position, the running CRC and both valid flags.
// A stall on m_axis holds the stage and the input register, then s_axis.
// ----------------------------------------------------------------------------
module thermocouple_scratchpad_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [tsd_pkg::IN_W-1:0]  s_axis_tdata_i,  // [7:0] scratch_byte
  input  logic                      s_axis_tuser_i,  // [0] frame_start
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [0] crc_ok, [12:1] cold_temp, [26:13] couple_temp, [29:27] fault_bits
  output logic [tsd_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import tsd_pkg::*;

  logic             in_vld_q, in_vld_d;
  logic [7:0]       in_byte_q;
  logic             in_start_q;
  logic             adv;
  logic             load_in;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       keep_q [KEEP_BYTES];

  logic [IDX_W-1:0] idx;
  logic             is_last;
  logic             step;
  logic [7:0]       crc_base;

  logic             out_vld_q, out_vld_d;
  result_t          res_q, res_d;

  logic [15:0]      cj_word;
  logic             good;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv || !in_vld_q;
  assign load_in         = s_axis_tready_o;
  assign in_vld_d        = load_in ? s_axis_tvalid_i : in_vld_q;

  assign step     = in_vld_q && adv;
  assign idx      = in_start_q ? '0 : idx_q;
  assign is_last  = idx >= LAST_IDX;
  assign crc_base = (idx == '0) ? 8'h00 : crc_q;

  always_comb begin
    idx_d = idx_q;
    crc_d = crc_q;
    if (step) begin
      if (is_last) begin
        idx_d = '0;
        crc_d = 8'h00;
      end else begin
        idx_d = idx + IDX_W'(1);
        crc_d = crc8_step(crc_base, in_byte_q);
      end
    end
  end

  assign cj_word = {keep_q[3], keep_q[2]};
  assign good    = (in_byte_q == crc_q);

  always_comb begin
    res_d = '0;
    if (good) begin
      res_d.crc_ok    = 1'b1;
      res_d.cold_temp = $signed(cj_word[15:4]);
      if (keep_q[0][0]) begin
        res_d.fault_bits = keep_q[2][2:0];
      end else begin
        res_d.couple_temp = $signed({keep_q[1], keep_q[0][7:2]});
      end
    end
  end

  assign out_vld_d = adv ? (in_vld_q && is_last) : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
      crc_q     <= 8'h00;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      idx_q     <= idx_d;
      crc_q     <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      in_byte_q  <= s_axis_tdata_i[7:0];
      in_start_q <= s_axis_tuser_i;
    end
    if (step && !is_last && idx < IDX_W'(KEEP_BYTES)) begin
      keep_q[idx[1:0]] <= in_byte_q;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(OUT_W - RES_W)'(0), res_q};

`include "thermocouple_scratchpad_decoder_defines.svh"

  `TSD_ASSERT_SAME(a_idx_range, 1'b1, idx_q <= LAST_IDX, "byte index beyond frame")
  `TSD_ASSERT_NEXT(a_no_mid_result, step && !is_last, !out_vld_q, "result from a middle byte")
  `TSD_ASSERT_NEXT(a_frame_restart, step && is_last,
                   idx_q == '0 && crc_q == 8'h00, "frame state not restarted")
  `TSD_ASSERT_SAME(a_bad_crc_zero, out_vld_q && !res_q.crc_ok,
                   res_q == '0, "bad CRC result not zero")
  `TSD_ASSERT_SAME(a_fault_excl, out_vld_q,
                   res_q.couple_temp == '0 || res_q.fault_bits == '0,
                   "fault and reading both set")

endmodule
